// ===== hw/rtl/sfr_pkg.sv =====
package sfr_pkg;

  localparam int unsigned CntW = 7;

  localparam logic [7:0] MAX_PAYLOAD    = 8'd96;
  localparam logic [7:0] SYNC_FIRST     = 8'hAA;
  localparam logic [7:0] SYNC_SECOND    = 8'h55;
  localparam logic [7:0] FRAME_VER      = 8'h01;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [7:0] ROLE_MASTER    = 8'h02;
  localparam logic [7:0] ROLE_SLAVE     = 8'h03;
  localparam logic [7:0] KIND_READ      = 8'h01;
  localparam logic [CntW-1:0] FRAME_OVERHEAD = 7'd13;

  localparam logic [7:0] GROUP_MIN = 8'd1;
  localparam logic [7:0] GROUP_MAX = 8'd4;

  // byte positions within a frame
  localparam logic [CntW-1:0] POS_HUNT     = 7'd0;
  localparam logic [CntW-1:0] POS_SYNC2    = 7'd1;
  localparam logic [CntW-1:0] POS_VERSION  = 7'd2;
  localparam logic [CntW-1:0] POS_KIND     = 7'd3;
  localparam logic [CntW-1:0] POS_SRC_ROLE = 7'd4;
  localparam logic [CntW-1:0] POS_SRC_GRP  = 7'd5;
  localparam logic [CntW-1:0] POS_DST_ROLE = 7'd6;
  localparam logic [CntW-1:0] POS_DST_GRP  = 7'd7;
  localparam logic [CntW-1:0] POS_FLOW_LO  = 7'd8;
  localparam logic [CntW-1:0] POS_FLOW_HI  = 7'd9;
  localparam logic [CntW-1:0] POS_LEN      = 7'd10;
  localparam logic [CntW-1:0] POS_PAYLOAD  = 7'd11;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_DONE = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_REQUEST   = 4'd1,
    ST_BAD_LEN   = 4'd2,
    ST_BAD_VER   = 4'd3,
    ST_BAD_CRC   = 4'd4,
    ST_FILTERED  = 4'd5,
    ST_BUSY_IGN  = 4'd6,
    ST_DROPPED   = 4'd7,
    ST_DONE_ACC  = 4'd8,
    ST_DONE_IGN  = 4'd9
  } status_e;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/sfr_in_if.sv =====
interface sfr_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  data_byte;
  logic [15:0] done_flow;

  modport source (output valid, output opcode, output data_byte, output done_flow,
                  input ready);
  modport sink   (input valid, input opcode, input data_byte, input done_flow,
                  output ready);
endinterface

// ===== hw/rtl/sfr_out_if.sv =====
interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [15:0] request_flow;
  logic        busy_res;

  modport source (output valid, output status, output request_flow, output busy_res,
                  input ready);
  modport sink   (input valid, input status, input request_flow, input busy_res,
                  output ready);
endinterface

// ===== hw/rtl/sync_frame_receiver_crc16_unit.sv =====
// Channel   Dir  Handshake      Payload
// in_i      in   valid/ready    opcode, data_byte, done_flow
// out_o     out  valid/ready    status, request_flow, busy_res
// cfg       in   cfg_we_i       cfg_wdata_i (node group id)
//
// One item per cycle while the output is not stalled: a transfer lands in the
// input register, then the parser and CRC byte update load the result register.
// rst_ni clears all parser state, the CRC to 0xFFFF and the node group to 0.
// A stalled output holds the result register; the input register keeps
// taking a transfer whenever the result register frees up in the same cycle.
module sync_frame_receiver_crc16_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  sfr_in_if.sink     in_i,
  sfr_out_if.source  out_o
);

  logic [7:0] node_grp_q;

  logic        in_valid_q;
  logic        in_op_q;
  logic [7:0]  in_byte_q;
  logic [15:0] in_flow_q;

  logic            out_valid_q;
  sfr_pkg::status_e status_q, status_d;
  logic [15:0]     req_flow_q;
  logic            busy_out_q;

  logic [sfr_pkg::CntW-1:0] byte_cnt_q, byte_cnt_d;
  logic [sfr_pkg::CntW-1:0] exp_total_q, exp_total_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      version_q, version_d;
  logic [7:0]      kind_q, kind_d;
  logic [7:0]      src_role_q, src_role_d;
  logic [7:0]      src_grp_q, src_grp_d;
  logic [7:0]      dst_role_q, dst_role_d;
  logic [7:0]      dst_grp_q, dst_grp_d;
  logic [15:0]     flow_q, flow_d;
  logic [sfr_pkg::CntW-1:0] pay_cnt_q, pay_cnt_d;
  logic [7:0]      first_pay_q, first_pay_d;
  logic [7:0]      crc_lo_q, crc_lo_d;
  logic            busy_q, busy_d;
  logic [15:0]     pend_flow_q, pend_flow_d;

  logic            advance;
  logic            group_ok;
  logic [sfr_pkg::CntW:0] idx_p1;
  logic [sfr_pkg::CntW:0] idx_p2;
  logic [sfr_pkg::CntW:0] exp_ext;
  logic            filter_ok;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.request_flow = req_flow_q;
  assign out_o.busy_res     = busy_out_q;

  assign group_ok = (node_grp_q >= sfr_pkg::GROUP_MIN) &&
                    (node_grp_q <= sfr_pkg::GROUP_MAX);
  assign idx_p1  = {1'b0, byte_cnt_q} + (sfr_pkg::CntW+1)'(1);
  assign idx_p2  = {1'b0, byte_cnt_q} + (sfr_pkg::CntW+1)'(2);
  assign exp_ext = {1'b0, exp_total_q};

  assign filter_ok = (kind_q == sfr_pkg::KIND_READ) &&
                     (src_role_q == sfr_pkg::ROLE_MASTER) &&
                     (dst_role_q == sfr_pkg::ROLE_SLAVE) &&
                     (src_grp_q == node_grp_q) &&
                     (dst_grp_q == node_grp_q) &&
                     (pay_cnt_q == sfr_pkg::CntW'(1)) &&
                     (first_pay_q <= 8'd1);

  always_comb begin
    byte_cnt_d  = byte_cnt_q;
    exp_total_d = exp_total_q;
    crc_d       = crc_q;
    version_d   = version_q;
    kind_d      = kind_q;
    src_role_d  = src_role_q;
    src_grp_d   = src_grp_q;
    dst_role_d  = dst_role_q;
    dst_grp_d   = dst_grp_q;
    flow_d      = flow_q;
    pay_cnt_d   = pay_cnt_q;
    first_pay_d = first_pay_q;
    crc_lo_d    = crc_lo_q;
    busy_d      = busy_q;
    pend_flow_d = pend_flow_q;
    status_d    = sfr_pkg::ST_IDLE;

    if (in_op_q == sfr_pkg::OP_DONE) begin
      if (busy_q && (in_flow_q == pend_flow_q)) begin
        busy_d   = 1'b0;
        status_d = sfr_pkg::ST_DONE_ACC;
      end else begin
        status_d = sfr_pkg::ST_DONE_IGN;
      end
    end else if (!group_ok) begin
      status_d = sfr_pkg::ST_DROPPED;
    end else if (byte_cnt_q == sfr_pkg::POS_HUNT) begin
      if (in_byte_q == sfr_pkg::SYNC_FIRST) begin
        byte_cnt_d = sfr_pkg::POS_SYNC2;
      end
    end else if (byte_cnt_q == sfr_pkg::POS_SYNC2) begin
      if (in_byte_q == sfr_pkg::SYNC_SECOND) begin
        byte_cnt_d = sfr_pkg::POS_VERSION;
        crc_d      = sfr_pkg::CRC_INIT;
      end else if (in_byte_q != sfr_pkg::SYNC_FIRST) begin
        byte_cnt_d  = sfr_pkg::POS_HUNT;
        exp_total_d = '0;
        crc_d       = sfr_pkg::CRC_INIT;
      end
    end else begin
      byte_cnt_d = idx_p1[sfr_pkg::CntW-1:0];
      if ((byte_cnt_q <= sfr_pkg::POS_LEN) ||
          ((exp_total_q != '0) && (idx_p2 < exp_ext))) begin
        crc_d = sfr_pkg::crc_byte(crc_q, in_byte_q);
      end
      unique case (byte_cnt_q)
        sfr_pkg::POS_VERSION:  version_d  = in_byte_q;
        sfr_pkg::POS_KIND:     kind_d     = in_byte_q;
        sfr_pkg::POS_SRC_ROLE: src_role_d = in_byte_q;
        sfr_pkg::POS_SRC_GRP:  src_grp_d  = in_byte_q;
        sfr_pkg::POS_DST_ROLE: dst_role_d = in_byte_q;
        sfr_pkg::POS_DST_GRP:  dst_grp_d  = in_byte_q;
        sfr_pkg::POS_FLOW_LO:  flow_d     = {flow_q[15:8], in_byte_q};
        sfr_pkg::POS_FLOW_HI:  flow_d     = {in_byte_q, flow_q[7:0]};
        sfr_pkg::POS_LEN: begin
          if (in_byte_q > sfr_pkg::MAX_PAYLOAD) begin
            byte_cnt_d  = sfr_pkg::POS_HUNT;
            exp_total_d = '0;
            crc_d       = sfr_pkg::CRC_INIT;
            status_d    = sfr_pkg::ST_BAD_LEN;
          end else begin
            pay_cnt_d   = in_byte_q[sfr_pkg::CntW-1:0];
            exp_total_d = sfr_pkg::FRAME_OVERHEAD + in_byte_q[sfr_pkg::CntW-1:0];
          end
        end
        default: begin
          if ((byte_cnt_q == sfr_pkg::POS_PAYLOAD) &&
              (exp_total_q > sfr_pkg::FRAME_OVERHEAD)) begin
            first_pay_d = in_byte_q;
          end
          if (idx_p2 == exp_ext) begin
            crc_lo_d = in_byte_q;
          end else if (idx_p1 == exp_ext) begin
            if (version_q != sfr_pkg::FRAME_VER) begin
              status_d = sfr_pkg::ST_BAD_VER;
            end else if ((crc_lo_q != crc_q[7:0]) || (in_byte_q != crc_q[15:8])) begin
              status_d = sfr_pkg::ST_BAD_CRC;
            end else if (!filter_ok) begin
              status_d = sfr_pkg::ST_FILTERED;
            end else if (busy_q) begin
              status_d = sfr_pkg::ST_BUSY_IGN;
            end else begin
              pend_flow_d = flow_q;
              busy_d      = 1'b1;
              status_d    = sfr_pkg::ST_REQUEST;
            end
            byte_cnt_d  = sfr_pkg::POS_HUNT;
            exp_total_d = '0;
            crc_d       = sfr_pkg::CRC_INIT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_grp_q <= '0;
    end else if (cfg_we_i) begin
      node_grp_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_op_q   <= in_i.opcode;
      in_byte_q <= in_i.data_byte;
      in_flow_q <= in_i.done_flow;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q   <= status_d;
      req_flow_q <= pend_flow_d;
      busy_out_q <= busy_d;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q  <= '0;
      exp_total_q <= '0;
      crc_q       <= sfr_pkg::CRC_INIT;
      version_q   <= '0;
      kind_q      <= '0;
      src_role_q  <= '0;
      src_grp_q   <= '0;
      dst_role_q  <= '0;
      dst_grp_q   <= '0;
      flow_q      <= '0;
      pay_cnt_q   <= '0;
      first_pay_q <= '0;
      crc_lo_q    <= '0;
      busy_q      <= 1'b0;
      pend_flow_q <= '0;
    end else if (advance) begin
      byte_cnt_q  <= byte_cnt_d;
      exp_total_q <= exp_total_d;
      crc_q       <= crc_d;
      version_q   <= version_d;
      kind_q      <= kind_d;
      src_role_q  <= src_role_d;
      src_grp_q   <= src_grp_d;
      dst_role_q  <= dst_role_d;
      dst_grp_q   <= dst_grp_d;
      flow_q      <= flow_d;
      pay_cnt_q   <= pay_cnt_d;
      first_pay_q <= first_pay_d;
      crc_lo_q    <= crc_lo_d;
      busy_q      <= busy_d;
      pend_flow_q <= pend_flow_d;
    end
  end

endmodule
